// ===== hdl/cbrt_pkg.sv =====
`timescale 1ns / 1ps

package cbrt_pkg;

  // Operand format
  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;

  // Scaled operand is operand * 2^(2*FRAC_BITS), non-negative part only
  localparam int SCALED_BITS = WORD_BITS - 1 + 2 * FRAC_BITS;
  // One root bit per 3-bit digit of the scaled operand
  localparam int ROOT_BITS   = (SCALED_BITS + 2) / 3;
  localparam int N_BITS      = 3 * ROOT_BITS;
  // Partial remainder is below 8 * (3y^2 + 3y + 1)
  localparam int REM_BITS    = 2 * ROOT_BITS + 5;
  // Running 3*y^2 and 3*y
  localparam int A_BITS      = 2 * ROOT_BITS + 2;
  localparam int B_BITS      = ROOT_BITS + 2;
  localparam int CNT_BITS    = $clog2(ROOT_BITS);
  localparam int SAT_BITS    = (ROOT_BITS > WORD_BITS) ? ROOT_BITS : WORD_BITS;

  localparam logic [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS - 1){1'b1}}};

  // Controller state codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  typedef struct packed {
    logic load;     // capture operand, clear iteration registers
    logic step;     // one root bit
    logic publish;  // move result into output register
  } cbrt_cmd_t;

  typedef struct packed {
    logic in_nonpos;  // operand at the input is zero or negative
    logic held_pass;  // captured operand takes the pass-through path
  } cbrt_status_t;

endpackage

// ===== hdl/cbrt_ctrl.sv =====
`timescale 1ns / 1ps

module cbrt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  cbrt_pkg::cbrt_status_t status,
  output cbrt_pkg::cbrt_cmd_t    cmd
);
  import cbrt_pkg::*;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [CNT_BITS-1:0] cnt;
  logic                out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.in_nonpos ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (cnt == '0) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) cnt <= CNT_BITS'(ROOT_BITS - 1);
      else if (cmd.step) cnt <= cnt - CNT_BITS'(1);
      if (cmd.publish) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.publish}))
    else $error("more than one datapath command");

  // result register never overwritten while a result waits
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || !out_stall))
    else $error("publish over a pending result");

  // after a load the input side is closed
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> in_stall)
    else $error("input open right after load");

  // pass-through skips the iteration
  a_pass_skip: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> !status.held_pass)
    else $error("iterating on a pass-through operand");

endmodule

// ===== hdl/cbrt_dp.sv =====
`timescale 1ns / 1ps

module cbrt_dp (
  input  logic                         clk,
  input  cbrt_pkg::cbrt_cmd_t           cmd,
  input  logic [cbrt_pkg::WORD_BITS-1:0] operand,
  output cbrt_pkg::cbrt_status_t        status,
  output logic [cbrt_pkg::WORD_BITS-1:0] root,
  output logic                         passed_through
);
  import cbrt_pkg::*;

  logic [WORD_BITS-1:0] op_hold;
  logic                 pass;
  logic [N_BITS-1:0]    n;
  logic [REM_BITS-1:0]  rem;
  logic [ROOT_BITS-1:0] y;
  logic [A_BITS-1:0]    a;   // 3*y^2
  logic [B_BITS-1:0]    b;   // 3*y

  logic [REM_BITS-1:0]  rem_sh;
  logic [A_BITS-1:0]    a2;
  logic [B_BITS-1:0]    b2;
  logic [REM_BITS-1:0]  t;
  logic                 take;
  logic [SAT_BITS-1:0]  y_ext;
  logic [WORD_BITS-1:0] root_val;

  assign status.in_nonpos = (operand == '0) || operand[WORD_BITS-1];
  assign status.held_pass = pass;

  // doubling y: 3y^2 -> 4x, 3y -> 2x; next increment is 3y^2 + 3y + 1
  assign rem_sh = {rem[REM_BITS-4:0], n[N_BITS-1 -: 3]};
  assign a2     = {a[A_BITS-3:0], 2'b00};
  assign b2     = {b[B_BITS-2:0], 1'b0};
  assign t      = REM_BITS'(a2) + REM_BITS'(b2) + REM_BITS'(1);
  assign take   = (rem_sh >= t);

  assign y_ext    = SAT_BITS'(y);
  assign root_val = (y_ext > SAT_BITS'(MAX_POS)) ? MAX_POS : WORD_BITS'(y_ext);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_hold <= operand;
      pass    <= status.in_nonpos;
      n       <= N_BITS'({operand[WORD_BITS-2:0], {(2 * FRAC_BITS){1'b0}}});
      rem     <= '0;
      y       <= '0;
      a       <= '0;
      b       <= '0;
    end else if (cmd.step) begin
      n <= {n[N_BITS-4:0], 3'b000};
      if (take) begin
        rem <= rem_sh - t;
        y   <= {y[ROOT_BITS-2:0], 1'b1};
        // 3(y+1)^2 = 3y^2 + 2*3y + 3
        a   <= a2 + A_BITS'({b2, 1'b0}) + A_BITS'(3);
        b   <= b2 + B_BITS'(3);
      end else begin
        rem <= rem_sh;
        y   <= {y[ROOT_BITS-2:0], 1'b0};
        a   <= a2;
        b   <= b2;
      end
    end
    if (cmd.publish) begin
      root           <= pass ? op_hold : root_val;
      passed_through <= pass;
    end
  end

endmodule

// ===== hdl/fixed_point_cube_root.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Payload
// input    in         in_valid/in_stall   operand (signed Q16.16)
// output   out        out_valid/out_stall root (signed Q16.16), passed_through
//
// Positive operand: a load, 21 root-bit steps at one root bit per cycle, then a
//   publish into the output register once the output is free.
// Zero or negative operand: no root steps; operand returned, passed_through set.
// Synchronous active-high reset clears the controller and output valid.
// in_stall is high from load until the result enters the output register; a
// stalled output holds the result and delays the next publish and next load.

module fixed_point_cube_root (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cbrt_pkg::WORD_BITS-1:0] operand,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cbrt_pkg::WORD_BITS-1:0] root,
  output logic                         passed_through
);
  import cbrt_pkg::*;

  cbrt_cmd_t    cmd;
  cbrt_status_t status;

  // Sequencer: idle / iterate / deliver, plus output valid
  cbrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Digit-by-digit cube root: 3 operand bits in, 1 root bit out per step
  cbrt_dp u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .operand        (operand),
    .status         (status),
    .root           (root),
    .passed_through (passed_through)
  );

endmodule

// ===== tb/tb_fixed_point_cube_root.sv =====
`timescale 1ns / 1ps

module tb_fixed_point_cube_root;

  import cbrt_pkg::*;

  // Clock, run length
  localparam int  HALF_PERIOD   = 5;
  localparam int  RESET_CYCLES  = 8;
  localparam int  LONG_HOLD     = 300;   // receiver hold-off, in cycles
  localparam int  HOLD_ITEMS    = 40;    // items offered while the receiver holds off
  localparam int  RANDOM_ITEMS  = 1000;  // random part, split over phases below
  localparam int  DRAIN_LIMIT   = 20000; // cycles allowed for the last results
  localparam int  TAIL_CYCLES   = 60;    // settle time after the last result
  localparam int  REPORT_LIMIT  = 10;
  // Highest candidate bit of the bitwise root search; cand^3 stays below 2^123
  localparam int  ROOT_TOP_BIT  = 40;

  // One result transaction as the block presents it
  typedef struct packed {
    logic [WORD_BITS-1:0] root;
    logic                 passed_through;
  } cube_result_t;

  // Predicts each accepted operand and checks results in order
  class cube_root_board;
    cube_result_t pending_q[$];
    int           mismatches;
    int           checked;
    int           pass_count;
    int           noted;

    function new();
      mismatches = 0;
      checked    = 0;
      pass_count = 0;
      noted      = 0;
    endfunction

    // floor(cbrt(op) * 2^FRAC_BITS), or op itself when op is not positive
    function cube_result_t cube_root_floor(logic [WORD_BITS-1:0] op);
      cube_result_t res;
      logic [127:0] scaled;
      logic [127:0] cand_w;
      logic [127:0] cand_cube;
      logic [63:0]  acc;
      logic [63:0]  cand;
      if (op == '0 || op[WORD_BITS-1]) begin
        res.root           = op;
        res.passed_through = 1'b1;
        return res;
      end
      scaled = {{(128 - WORD_BITS){1'b0}}, op} << (2 * FRAC_BITS);
      acc    = '0;
      for (int b = ROOT_TOP_BIT; b >= 0; b--) begin
        cand      = acc | (64'd1 << b);
        cand_w    = {64'd0, cand};
        cand_cube = cand_w * cand_w * cand_w;
        if (cand_cube <= scaled) acc = cand;
      end
      if (acc > {{(64 - WORD_BITS){1'b0}}, MAX_POS}) acc = {{(64 - WORD_BITS){1'b0}}, MAX_POS};
      res.root           = acc[WORD_BITS-1:0];
      res.passed_through = 1'b0;
      return res;
    endfunction

    function void note_operand(logic [WORD_BITS-1:0] op);
      pending_q.push_back(cube_root_floor(op));
      noted++;
    endfunction

    function void check_result(logic [WORD_BITS-1:0] root, logic passed_through);
      cube_result_t want;
      checked++;
      if (passed_through === 1'b1) pass_count++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] unexpected result: root=%h passed_through=%b",
                   $realtime, root, passed_through);
        return;
      end
      want = pending_q.pop_front();
      if (root !== want.root || passed_through !== want.passed_through) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] mismatch: root exp=%h got=%h, passed_through exp=%b got=%b",
                   $realtime, want.root, root, want.passed_through, passed_through);
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // Anything still waiting at the end is a failure
    function void close_out();
      if (pending_q.size() != 0) begin
        mismatches += pending_q.size();
        $display("%0d expected results never arrived", pending_q.size());
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [WORD_BITS-1:0] operand;
  logic                 out_valid;
  logic                 out_stall;
  logic [WORD_BITS-1:0] root;
  logic                 passed_through;

  cube_root_board board;

  // Idling control shared by sender and receiver
  bit quiet_mode;        // no gaps on either side
  int hold_left;         // receiver hold-off still to run, counted by the receiver
  bit hold_seen_full;    // input stalled during the hold-off
  int sent_count;

  fixed_point_cube_root DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operand        (operand),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .root           (root),
    .passed_through (passed_through)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(16, 60);
  endfunction

  // Random operand mix: non-positive, small, near perfect cubes, full range
  function automatic logic [WORD_BITS-1:0] pick_operand();
    int                   r;
    logic [63:0]          k;
    logic [63:0]          kc;
    logic [WORD_BITS-1:0] op;
    r = $urandom_range(0, 99);
    if (r < 18) begin
      if ($urandom_range(0, 9) == 0) op = '0;
      else op = {1'b1, 31'($urandom)};
    end else if (r < 38) begin
      op = 32'($urandom) >> $urandom_range(1, 31);
      if (op == '0) op = 32'd1;
    end else if (r < 52) begin
      // scaled operand right at or just above k^3, or just under it, so the last root bit is decisive
      k  = 64'($urandom_range(1, (1 << 21) - 1));
      kc = k * k * k;
      op = 32'((kc + 64'hFFFF_FFFF) >> 32);
      if ($urandom_range(0, 1) == 1 && op > 32'd1) op = op - 32'd1;
    end else begin
      op = 32'($urandom);
    end
    return op;
  endfunction

  // Offer one operand; called and returns at a falling edge
  task automatic send_operand(input logic [WORD_BITS-1:0] op);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operand  <= op;
    @(posedge clk);
    while (in_stall) begin
      if (hold_left > 0) hold_seen_full = 1'b1;
      @(posedge clk);
    end
    board.note_operand(op);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_operand(pick_operand());
  endtask

  // Sender pause: nothing more until every result is back
  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
  endtask

  // Receiver: one stall decision per falling edge
  initial begin : receiver
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left   = 0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (stall_left == 0 && run_left == 0) begin
          stall_left = pick_gap();
          run_left   = quiet_mode ? 64 : $urandom_range(1, 12);
        end
        if (stall_left > 0) begin
          out_stall <= 1'b1;
          stall_left--;
        end else begin
          out_stall <= 1'b0;
          run_left--;
        end
      end
    end
  end

  // Result monitor: values seen here are the ones before the edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(root, passed_through);
  end

  // Hard stop well past the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("fixed_point_cube_root verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [WORD_BITS-1:0] directed_ops[$];
    board          = new();
    quiet_mode     = 1'b0;
    hold_left      = 0;
    hold_seen_full = 1'b0;
    sent_count     = 0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    operand        = '0;
    out_stall      = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero, sign extremes, tiny values, perfect cubes and their neighbors
    directed_ops = '{
      32'h0000_0000,  // zero takes the pass-through path
      32'hFFFF_FFFF,  // -1 lsb
      32'h8000_0000,  // most negative
      32'hFFFF_0000,  // -1.0
      32'h0000_0001,  // smallest positive
      32'h0000_0002,
      32'h0000_0008,
      32'h0000_4000,  // 0.25
      32'h0000_FFFF,  // just under 1.0
      32'h0001_0000,  // 1.0, exact cube
      32'h0001_0001,
      32'h0007_FFFF,  // just under 8.0
      32'h0008_0000,  // 8.0
      32'h001B_0000,  // 27.0
      32'h0040_0000,  // 64.0
      32'h4000_0000,
      32'h7FFF_0000,
      32'h7FFF_FFFE,
      32'h7FFF_FFFF,  // largest positive
      32'h5555_5555,
      32'h2AAA_AAAA,
      32'hAAAA_AAAA
    };
    foreach (directed_ops[i]) send_operand(directed_ops[i]);
    wait_drained();

    // Random with gaps on both sides
    send_random(RANDOM_ITEMS / 2);

    // Receiver holds off while the sender keeps offering: the block backs up
    @(negedge clk);
    hold_left = LONG_HOLD;
    send_random(HOLD_ITEMS);
    wait_drained();

    // Back-to-back with no idling anywhere
    quiet_mode = 1'b1;
    send_random(RANDOM_ITEMS / 5);
    quiet_mode = 1'b0;

    send_random(RANDOM_ITEMS - RANDOM_ITEMS / 2 - RANDOM_ITEMS / 5 - HOLD_ITEMS);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    board.close_out();

    $display("sent %0d operands, checked %0d roots (%0d pass-through)",
             sent_count, board.checked, board.pass_count);
    $display("long receiver hold-off %s the input; %0d mismatches",
             hold_seen_full ? "backed up" : "did not back up", board.mismatches);
    if (board.mismatches == 0) begin
      $display("fixed_point_cube_root verification clean");
    end else begin
      $display("fixed_point_cube_root verification failed");
    end
    $finish;
  end

endmodule
